// ----- src/bfa_pkg.sv -----
// Bitmap frame allocator: shared types, request codes and default sizes.
// Used by bfa_ctrl, bfa_datapath and bitmap_frame_allocator. No dependencies.
`default_nettype none

package bfa_pkg;

    localparam int NUM_FRAMES_DEF = 4096;
    localparam int WORD_BITS_DEF  = 32;

    localparam int LIMIT_W = 13;
    localparam int FRAME_W = 12;

    localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RESET = 13'd4096;

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_FREE    = 2'd1;
    localparam logic [1:0] REQ_RESERVE = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [FRAME_W-1:0] frame_index;
    } req_t;

    typedef struct packed {
        logic [FRAME_W-1:0] granted_frame;
        logic               status;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic advance;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic scan_done;
    } sts_t;

endpackage

`default_nettype wire

// ----- src/bitmap_frame_allocator.sv -----
// Bitmap first-fit page-frame allocator, top level.
// Depends on bfa_pkg, bfa_ctrl and bfa_datapath.
//
// Channels: s_* carries one request (allocate, free or reserve a frame), m_* returns
// one response per request (granted frame, none-free status). cfg_* writes the
// frame limit and is always ready; the user must write it only while the block is
// idle, which the block does not enforce. Throughput: one request at a time. A
// request is accepted in the idle state, then the bitmap memory is walked one word
// per cycle from word 0; an allocate stops at the first word with a free bit below
// the limit or at the first word past the limit, a free or reserve at the word
// holding its frame, and every walk stops at the last word. The single memory read
// port sets the walk rate; MAP_WORDS is 128 at 4096 frames of 32-bit words.
// A request that is out of range or not recognised ends the walk on word 0 and
// goes straight to the response.
// The response is held in an output register until m_ready; no new request is
// taken until it has been delivered.
// Reset: the frame limit returns to 4096 and a clearing pass writes zero to every
// bitmap word, one word per cycle. s_ready stays low during the pass.
`default_nettype none

module bitmap_frame_allocator #(
    parameter int NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEF,
    parameter int WORD_BITS  = bfa_pkg::WORD_BITS_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [bfa_pkg::LIMIT_W-1:0]  cfg_data,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  bfa_pkg::req_t                s_req,
    output logic                         m_valid,
    input  wire                          m_ready,
    output bfa_pkg::rsp_t                m_rsp
);
    import bfa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    bfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    bfa_datapath #(
        .NUM_FRAMES (NUM_FRAMES),
        .WORD_BITS  (WORD_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_req     (s_req),
        .cmd       (cmd),
        .sts       (sts),
        .m_rsp     (m_rsp)
    );

endmodule

`default_nettype wire

// ----- src/bfa_ctrl.sv -----
// Bitmap frame allocator controller: clear / idle / scan / response sequencing.
// Depends on bfa_pkg; drives the commands consumed by bfa_datapath.
`default_nettype none

module bfa_ctrl (
    input  wire           aclk,
    input  wire           aresetn,
    input  wire           s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire           m_ready,
    output bfa_pkg::cmd_t cmd,
    input  bfa_pkg::sts_t sts
);
    import bfa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sts.scan_done) begin
                    cmd.finish = 1'b1;
                    state_next = ST_RESP;
                end else begin
                    cmd.advance = 1'b1;
                end
            end
            ST_RESP: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    a_accept_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_SCAN)
        else $error("accepted transaction did not start a scan");

    a_finish_gives_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_valid && !s_ready)
        else $error("finished scan did not present a response");

    a_resp_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.finish))
        else $error("response raised without a finished scan");

endmodule

`default_nettype wire

// ----- src/bfa_datapath.sv -----
// Bitmap frame allocator datapath: bitmap memory, word walk, bit search, limit register.
// Depends on bfa_pkg; sequenced by bfa_ctrl.
`default_nettype none

module bfa_datapath #(
    parameter int NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEF,
    parameter int WORD_BITS  = bfa_pkg::WORD_BITS_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [bfa_pkg::LIMIT_W-1:0]  cfg_data,
    input  bfa_pkg::req_t                s_req,
    input  bfa_pkg::cmd_t                cmd,
    output bfa_pkg::sts_t                sts,
    output bfa_pkg::rsp_t                m_rsp
);
    import bfa_pkg::*;

    localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = $clog2(MAP_WORDS * WORD_BITS) + 1;
    localparam int LW        = (BW > LIMIT_W) ? BW : LIMIT_W;
    localparam int OW        = $clog2(WORD_BITS);

    localparam logic [LW-1:0] NUM_FRAMES_L = LW'(NUM_FRAMES);
    localparam logic [LW-1:0] WORD_BITS_L  = LW'(WORD_BITS);
    localparam logic [AW-1:0] LAST_WORD    = AW'(MAP_WORDS - 1);

    logic [WORD_BITS-1:0] frame_map_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;

    logic [LIMIT_W-1:0]   limit_reg;
    req_t                 req_reg;
    rsp_t                 rsp_reg;
    rsp_t                 rsp_next;
    logic [AW-1:0]        ptr_reg;
    logic [AW-1:0]        ptr_next;
    logic [LW-1:0]        base_reg;
    logic [LW-1:0]        base_next;

    logic [LW-1:0]        lim_eff;
    logic [LW-1:0]        rem;
    logic                 in_range;
    logic [WORD_BITS-1:0] valid_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] first_bit;
    logic                 found;
    logic [OW-1:0]        pos;
    logic [LW-1:0]        idx_ext;
    logic [LW-1:0]        off;
    logic                 oor;
    logic                 hit;
    logic [WORD_BITS-1:0] idx_bit;
    logic                 last;
    logic                 scan_done;
    logic                 wr_hit;
    logic [WORD_BITS-1:0] wr_word;
    logic [LW-1:0]        grant_full;
    logic                 mem_we;
    logic [WORD_BITS-1:0] mem_wd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= FRAME_LIMIT_RESET;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    // search window: bits below min(limit, capacity)
    always_comb begin
        lim_eff  = (LW'(limit_reg) > NUM_FRAMES_L) ? NUM_FRAMES_L : LW'(limit_reg);
        in_range = lim_eff > base_reg;
        rem      = lim_eff - base_reg;
        for (int b = 0; b < WORD_BITS; b++) begin
            valid_mask[b] = in_range && (LW'(b) < rem);
        end
        free_bits = ~rd_data_reg & valid_mask;
        first_bit = free_bits & (~free_bits + WORD_BITS'(1));
        found     = |free_bits;
        pos       = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (first_bit[b]) begin
                pos = pos | OW'(b);
            end
        end
    end

    always_comb begin
        idx_ext = LW'(req_reg.frame_index);
        oor     = idx_ext >= NUM_FRAMES_L;
        off     = idx_ext - base_reg;
        hit     = off < WORD_BITS_L;
        idx_bit = WORD_BITS'(1) << off[OW-1:0];
        last    = ptr_reg == LAST_WORD;
    end

    always_comb begin
        scan_done = 1'b1;
        wr_hit    = 1'b0;
        wr_word   = rd_data_reg;
        unique case (req_reg.req_type)
            REQ_ALLOC: begin
                scan_done = !in_range || found || last;
                wr_hit    = found;
                wr_word   = rd_data_reg | first_bit;
            end
            REQ_FREE: begin
                scan_done = oor || hit || last;
                wr_hit    = hit && !oor;
                wr_word   = rd_data_reg & ~idx_bit;
            end
            REQ_RESERVE: begin
                scan_done = oor || hit || last;
                wr_hit    = hit && !oor;
                wr_word   = rd_data_reg | idx_bit;
            end
            default: begin
                scan_done = 1'b1;
                wr_hit    = 1'b0;
            end
        endcase
    end

    always_comb begin
        grant_full             = base_reg + LW'(pos);
        rsp_next.status        = (req_reg.req_type == REQ_ALLOC) && !found;
        rsp_next.granted_frame = ((req_reg.req_type == REQ_ALLOC) && found)
                               ? grant_full[FRAME_W-1:0] : '0;
    end

    always_comb begin
        sts.scan_done  = scan_done;
        sts.clear_last = last;
    end

    always_comb begin
        ptr_next  = ptr_reg;
        base_next = base_reg;
        if (cmd.clear_step) begin
            ptr_next = last ? '0 : ptr_reg + AW'(1);
        end else if (cmd.advance) begin
            ptr_next  = ptr_reg + AW'(1);
            base_next = base_reg + WORD_BITS_L;
        end else if (cmd.finish || cmd.load) begin
            ptr_next  = '0;
            base_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg  <= '0;
            base_reg <= '0;
        end else begin
            ptr_reg  <= ptr_next;
            base_reg <= base_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= s_req;
        end
        if (cmd.finish) begin
            rsp_reg <= rsp_next;
        end
    end

    assign m_rsp = rsp_reg;

    // read address follows the next pointer so data lines up with ptr_reg
    assign mem_we = cmd.clear_step || (cmd.finish && wr_hit);
    assign mem_wd = cmd.clear_step ? '0 : wr_word;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_map_mem[ptr_reg] <= mem_wd;
        end
        rd_data_reg <= frame_map_mem[ptr_next];
    end

    a_walk_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.advance |-> ptr_reg != LAST_WORD && base_next > base_reg)
        else $error("word walk ran past the end of the bitmap");

endmodule

`default_nettype wire

// ----- dv/bitmap_frame_allocator_tb.sv -----
// Self-checking testbench for bitmap_frame_allocator: directed and random allocate,
// free and reserve traffic across several frame limits, with a bitmap scoreboard.
// Depends on bfa_pkg and the bitmap_frame_allocator RTL.
`default_nettype none

module bitmap_frame_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfa_pkg::*;

    localparam int NFRAMES   = NUM_FRAMES_DEF;
    localparam int WBITS     = WORD_BITS_DEF;
    localparam int MAP_WORDS = (NFRAMES + WBITS - 1) / WBITS;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    class frame_map_scoreboard;
        logic [WBITS-1:0]   frame_words [MAP_WORDS];
        logic [LIMIT_W-1:0] frame_limit;
        rsp_t               expected_grants [$];
        int unsigned        mismatches;

        function new();
            foreach (frame_words[i]) frame_words[i] = '0;
            frame_limit = FRAME_LIMIT_RESET;
            mismatches  = 0;
        endfunction

        function rsp_t predict_response(input req_t r);
            rsp_t        e;
            int unsigned lim;
            int unsigned w;
            int unsigned b;
            bit          found;
            e     = '0;
            found = 1'b0;
            case (r.req_type)
                REQ_ALLOC: begin
                    lim = (frame_limit > NFRAMES) ? NFRAMES : frame_limit;
                    for (w = 0; w < MAP_WORDS && !found && w * WBITS < lim; w++) begin
                        if (frame_words[w] != '1) begin
                            for (b = 0; b < WBITS && !found && w * WBITS + b < lim; b++) begin
                                if (!frame_words[w][b]) begin
                                    frame_words[w][b] = 1'b1;
                                    e.granted_frame   = FRAME_W'(w * WBITS + b);
                                    found             = 1'b1;
                                end
                            end
                        end
                    end
                    if (!found) begin
                        e.granted_frame = '0;
                        e.status        = 1'b1;
                    end
                end
                REQ_FREE: begin
                    if (r.frame_index < NFRAMES)
                        frame_words[r.frame_index / WBITS][r.frame_index % WBITS] = 1'b0;
                end
                REQ_RESERVE: begin
                    if (r.frame_index < NFRAMES)
                        frame_words[r.frame_index / WBITS][r.frame_index % WBITS] = 1'b1;
                end
                default: ;
            endcase
            return e;
        endfunction

        function void note_request(input req_t r);
            expected_grants.push_back(predict_response(r));
        endfunction

        function void check_response(input rsp_t got);
            rsp_t e;
            if (expected_grants.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response with no request outstanding: frame %0d status %0d",
                             got.granted_frame, got.status);
                return;
            end
            e = expected_grants.pop_front();
            if (got.granted_frame !== e.granted_frame || got.status !== e.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected frame %0d status %0d, got frame %0d status %0d",
                             e.granted_frame, e.status, got.granted_frame, got.status);
            end
        endfunction

        function int unsigned failures();
            return mismatches + expected_grants.size();
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data;
    logic               s_valid;
    logic               s_ready;
    req_t               s_req;
    logic               m_valid;
    logic               m_ready;
    rsp_t               m_rsp;

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;

    frame_map_scoreboard book = new();

    bitmap_frame_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_rsp     (m_rsp)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("[bitmap_frame_allocator] ERROR");
        $finish;
    end

    // response side: random stall after each transaction while rx_idle is set
    initial begin : response_sink
        int stall;
        stall = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
                book.check_response(m_rsp);
                stall = rx_idle ? $urandom_range(0, 12) : 0;
            end else if (stall > 0) begin
                stall--;
            end
            m_ready <= (stall == 0);
        end
    end

    function automatic req_t make_req(input logic [1:0] kind, input int unsigned idx);
        req_t r;
        r.req_type    = kind;
        r.frame_index = idx[FRAME_W-1:0];
        return r;
    endfunction

    task automatic issue_request(input req_t r);
        int gap;
        gap = tx_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= r;
        do @(posedge aclk); while (s_ready !== 1'b1);
        book.note_request(r);
    endtask

    task automatic wait_all_granted();
        s_valid <= 1'b0;
        while (book.expected_grants.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        book.frame_limit = v;
    endtask

    initial begin
        int unsigned        alloc_pct;
        int unsigned        roll;
        int unsigned        lim;
        int unsigned        hi;
        int unsigned        idx;
        logic [1:0]         kind;
        logic [LIMIT_W-1:0] new_limit;

        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_req     <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        // bitmap clearing pass
        do @(posedge aclk); while (s_ready !== 1'b1);

        write_limit(FRAME_LIMIT_RESET);
        issue_request(make_req(REQ_ALLOC, 0));
        issue_request(make_req(REQ_ALLOC, 0));
        issue_request(make_req(REQ_FREE, 0));
        issue_request(make_req(REQ_ALLOC, 0));
        issue_request(make_req(REQ_RESERVE, 2));
        issue_request(make_req(REQ_ALLOC, 0));
        issue_request(make_req(REQ_RESERVE, 2));
        issue_request(make_req(REQ_FREE, 5));
        issue_request(make_req(REQ_UNKNOWN, 4095));
        issue_request(make_req(REQ_RESERVE, 4095));
        issue_request(make_req(REQ_FREE, 4095));
        issue_request(make_req(REQ_ALLOC, 4095));

        wait_all_granted();
        write_limit('0);
        issue_request(make_req(REQ_ALLOC, 0));
        issue_request(make_req(REQ_RESERVE, 100));
        issue_request(make_req(REQ_FREE, 100));

        wait_all_granted();
        write_limit(1);
        issue_request(make_req(REQ_ALLOC, 0));
        issue_request(make_req(REQ_FREE, 0));
        issue_request(make_req(REQ_ALLOC, 0));
        issue_request(make_req(REQ_ALLOC, 0));

        wait_all_granted();
        write_limit('1);
        issue_request(make_req(REQ_ALLOC, 0));
        issue_request(make_req(REQ_ALLOC, 0));

        for (int phase = 0; phase < 10; phase++) begin
            wait_all_granted();
            case ($urandom_range(0, 9))
                0: new_limit = 0;
                1: new_limit = 1;
                2: new_limit = 31;
                3: new_limit = 32;
                4: new_limit = 33;
                5: new_limit = LIMIT_W'(64 + $urandom_range(0, 1));
                6: new_limit = LIMIT_W'($urandom_range(2, 200));
                7: new_limit = LIMIT_W'($urandom_range(1, 4096));
                8: new_limit = FRAME_LIMIT_RESET;
                default: new_limit = LIMIT_W'($urandom_range(4097, 8191));
            endcase
            write_limit(new_limit);
            tx_idle   = ($urandom_range(0, 2) != 0);
            rx_idle   = ($urandom_range(0, 2) != 0);
            alloc_pct = $urandom_range(30, 85);
            lim       = (new_limit > NFRAMES) ? NFRAMES : new_limit;
            hi        = (lim + 8 > NFRAMES) ? NFRAMES - 1 : lim + 7;
            for (int n = 0; n < 65; n++) begin
                if ($urandom_range(0, 49) == 0)
                    wait_all_granted();
                roll = $urandom_range(0, 99);
                if (roll < alloc_pct)
                    kind = REQ_ALLOC;
                else if (roll < alloc_pct + (100 - alloc_pct) * 6 / 10)
                    kind = REQ_FREE;
                else if (roll < 96)
                    kind = REQ_RESERVE;
                else
                    kind = REQ_UNKNOWN;
                if ($urandom_range(0, 3) == 0)
                    idx = $urandom_range(0, NFRAMES - 1);
                else
                    idx = $urandom_range(0, hi);
                issue_request(make_req(kind, idx));
            end
        end

        wait_all_granted();
        repeat (200) @(posedge aclk);
        if (book.failures() == 0) begin
            $display("[bitmap_frame_allocator] OK");
        end else begin
            $display("[bitmap_frame_allocator] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- bitmap_frame_allocator.f -----
src/bfa_pkg.sv
src/bfa_ctrl.sv
src/bfa_datapath.sv
src/bitmap_frame_allocator.sv
dv/bitmap_frame_allocator_tb.sv
